>>> rtl/mask_channel_pixel_repack_macros.svh
// Assertion macros shared by the checker of the pixel repack block.
// No dependencies; the including module must provide clk and rst_n.
`ifndef MASK_CHANNEL_PIXEL_REPACK_MACROS_SVH
`define MASK_CHANNEL_PIXEL_REPACK_MACROS_SVH

// Checked only outside reset.
`define MCPR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mcpr assertion failed");

// Checked during reset as well.
`define MCPR_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mcpr reset assertion failed");

`endif

>>> rtl/mcpr_pkg.sv
// Package for the pixel repack block: widths, payload structs, register map.
// No dependencies.
`timescale 1ns / 1ps

package mcpr_pkg;

  localparam int PIXEL_BITS   = 32;
  localparam int RANK_W       = $clog2(PIXEL_BITS);
  localparam int NUM_CHANNELS = 4;
  localparam int NUM_REGS     = 8;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = $clog2(NUM_REGS) + 2;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  // Register indexes, byte address = 4 * index
  typedef enum logic [$clog2(NUM_REGS)-1:0] {
    REG_SRC_RED   = 3'd0,
    REG_SRC_GREEN = 3'd1,
    REG_SRC_BLUE  = 3'd2,
    REG_SRC_ALPHA = 3'd3,
    REG_DST_RED   = 3'd4,
    REG_DST_GREEN = 3'd5,
    REG_DST_BLUE  = 3'd6,
    REG_DST_ALPHA = 3'd7
  } reg_idx_t;

  localparam pixel_t MASK_RED_RST   = pixel_t'(32'h0000_00ff);
  localparam pixel_t MASK_GREEN_RST = pixel_t'(32'h0000_ff00);
  localparam pixel_t MASK_BLUE_RST  = pixel_t'(32'h00ff_0000);
  localparam pixel_t MASK_ALPHA_RST = pixel_t'(32'hff00_0000);

  typedef struct packed {
    pixel_t pixel_in;
    logic   last_in;
  } in_req_t;

  typedef struct packed {
    pixel_t pixel_out;
    logic   last_out;
  } out_req_t;

  // Channel masks handed from the register file to the datapath
  typedef struct packed {
    logic [NUM_CHANNELS-1:0][PIXEL_BITS-1:0] src_mask;
    logic [NUM_CHANNELS-1:0][PIXEL_BITS-1:0] dst_mask;
  } masks_t;

endpackage

>>> rtl/mcpr_cfg.sv
// APB-style register file holding the eight channel masks.
// Depends on mcpr_pkg.
`timescale 1ns / 1ps

module mcpr_cfg
  import mcpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output masks_t                masks
);

  pixel_t   mask_r [NUM_REGS];
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r[REG_SRC_RED]   <= MASK_RED_RST;
      mask_r[REG_SRC_GREEN] <= MASK_GREEN_RST;
      mask_r[REG_SRC_BLUE]  <= MASK_BLUE_RST;
      mask_r[REG_SRC_ALPHA] <= MASK_ALPHA_RST;
      mask_r[REG_DST_RED]   <= MASK_RED_RST;
      mask_r[REG_DST_GREEN] <= MASK_GREEN_RST;
      mask_r[REG_DST_BLUE]  <= MASK_BLUE_RST;
      mask_r[REG_DST_ALPHA] <= MASK_ALPHA_RST;
    end else if (wr_en) begin
      mask_r[idx] <= pixel_t'(cfg_pwdata);
    end
  end

  assign cfg_prdata = CFG_DATA_W'(mask_r[idx]);
  assign cfg_pready = 1'b1;

  always_comb begin
    masks.src_mask[0] = mask_r[REG_SRC_RED];
    masks.src_mask[1] = mask_r[REG_SRC_GREEN];
    masks.src_mask[2] = mask_r[REG_SRC_BLUE];
    masks.src_mask[3] = mask_r[REG_SRC_ALPHA];
    masks.dst_mask[0] = mask_r[REG_DST_RED];
    masks.dst_mask[1] = mask_r[REG_DST_GREEN];
    masks.dst_mask[2] = mask_r[REG_DST_BLUE];
    masks.dst_mask[3] = mask_r[REG_DST_ALPHA];
  end

endmodule

>>> rtl/mcpr_chan.sv
// One channel of the repack: bit extract by source mask, bit deposit by
// destination mask. Purely combinational. Depends on mcpr_pkg.
`timescale 1ns / 1ps

module mcpr_chan
  import mcpr_pkg::*;
(
  input  pixel_t pixel,
  input  pixel_t src_mask,
  input  pixel_t dst_mask,
  output pixel_t deposit
);

  logic [RANK_W-1:0] src_rank [PIXEL_BITS];
  logic [RANK_W-1:0] dst_rank [PIXEL_BITS];
  pixel_t            gathered;

  // Rank of each position = number of mask bits below it. Masks are static
  // while pixels flow, so this is off the pixel path.
  always_comb begin
    for (int i = 0; i < PIXEL_BITS; i++) begin
      src_rank[i] = RANK_W'($countones(src_mask & ~({PIXEL_BITS{1'b1}} << i)));
      dst_rank[i] = RANK_W'($countones(dst_mask & ~({PIXEL_BITS{1'b1}} << i)));
    end
  end

  // Compact bit k collects the source bit whose rank is k
  always_comb begin
    gathered = '0;
    for (int k = 0; k < PIXEL_BITS; k++) begin
      for (int i = 0; i < PIXEL_BITS; i++) begin
        gathered[k] = gathered[k] |
                      (pixel[i] & src_mask[i] & (src_rank[i] == RANK_W'(k)));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < PIXEL_BITS; i++) begin
      deposit[i] = dst_mask[i] & gathered[dst_rank[i]];
    end
  end

endmodule

>>> rtl/mask_channel_pixel_repack.sv
// Top level of the pixel repack block: register file, input and result
// registers, four channel units. Depends on mcpr_pkg, mcpr_cfg, mcpr_chan.
//
// Usage:
//   in_*  : request channel, one pixel word plus last flag per request,
//           taken at a clock edge where in_valid is high and in_stall low.
//   out_* : result channel, one repacked pixel per input request, in order,
//           taken where out_valid is high and out_stall low.
//   cfg_* : APB-style port, eight 32-bit channel masks at byte address 4*i,
//           source red/green/blue/alpha then destination red/green/blue/alpha.
//           Write masks only while no pixel is in flight.
// Path: a request taken on in_* passes the input register, then the result
//   register, before it shows on out_*.
// Throughput: one pixel per cycle while out_stall stays low; the repack of a word is one pass of
//   extract/deposit logic between the input register and the result register.
// Reset (rst_n low, synchronous): both pipeline stages empty, masks return to
//   the byte-lane layout red=7:0, green=15:8, blue=23:16, alpha=31:24.
// Stall: while out_stall holds a result, the input register still takes one
//   more request; after that in_stall rises until the result register frees.
`timescale 1ns / 1ps

module mask_channel_pixel_repack
  import mcpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_req_t              out_data,
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  masks_t   masks;

  // input register stage
  logic     s1_valid_r, s1_valid_nxt;
  in_req_t  s1_data_r;
  // result register stage
  logic     out_valid_r, out_valid_nxt;
  out_req_t out_data_r;

  logic     s2_load;
  logic     s1_load;
  pixel_t   chan_dep [NUM_CHANNELS];
  pixel_t   repacked;

  mcpr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .masks       (masks)
  );

  // Result register is free when empty or being drained this cycle
  assign s2_load  = !out_valid_r || !out_stall;
  // Input register is free when empty or moving into the result register
  assign s1_load  = !s1_valid_r || s2_load;
  assign in_stall = !s1_load;

  assign s1_valid_nxt  = s1_load ? in_valid : s1_valid_r;
  assign out_valid_nxt = s2_load ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // Four independent channels; overlapping destinations OR together
  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    mcpr_chan u_chan (
      .pixel    (s1_data_r.pixel_in),
      .src_mask (masks.src_mask[c]),
      .dst_mask (masks.dst_mask[c]),
      .deposit  (chan_dep[c])
    );
  end

  always_comb begin
    repacked = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      repacked = repacked | chan_dep[c];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid_r) begin
      out_data_r.pixel_out <= repacked;
      out_data_r.last_out  <= s1_data_r.last_in;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/mcpr_checker.sv
// Port-level checker for the pixel repack block, bound to the top level.
// Depends on mcpr_pkg and mask_channel_pixel_repack_macros.svh.
`timescale 1ns / 1ps
`include "mask_channel_pixel_repack_macros.svh"

module mcpr_checker
  import mcpr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input out_req_t out_data
);

  // held result stays offered
  `MCPR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)
  `MCPR_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_data))
  // input backs up only behind a blocked result
  `MCPR_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall)
  // an accepted request moves on into the result register next if that register is free
  `MCPR_ASSERT(a_latency, in_valid && !in_stall ##1 !out_stall |=> out_valid)
  // reset empties the pipeline
  `MCPR_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid)

endmodule

bind mask_channel_pixel_repack mcpr_checker u_mcpr_checker (.*);

>>> tb/tb_mask_channel_pixel_repack.sv
// Self-checking testbench for mask_channel_pixel_repack: random mask layouts and pixels
// are checked against a bit extract/deposit predictor held in a small scoreboard class.
// Depends on mcpr_pkg and the mask_channel_pixel_repack RTL.
`timescale 1ns / 1ps

module tb_mask_channel_pixel_repack;
  import mcpr_pkg::*;

  localparam int HOLD_CYCLES  = 64;        // long result-side hold-off
  localparam int DRAIN_LIMIT  = 2000;      // cycles to wait for outstanding pixels
  localparam int RUN_LIMIT_NS = 2_000_000; // hard stop for a hung run
  localparam int RAND_PHASES  = 14;
  localparam int PHASE_ITEMS  = 112;

  // Expected-pixel store plus the repack predictor. The masks are the
  // testbench's own copy of the register file.
  class repack_scoreboard;
    pixel_t   mask_reg[NUM_REGS];
    out_req_t pending[$];
    int       errors;

    function new();
      mask_reg[REG_SRC_RED]   = MASK_RED_RST;
      mask_reg[REG_SRC_GREEN] = MASK_GREEN_RST;
      mask_reg[REG_SRC_BLUE]  = MASK_BLUE_RST;
      mask_reg[REG_SRC_ALPHA] = MASK_ALPHA_RST;
      mask_reg[REG_DST_RED]   = MASK_RED_RST;
      mask_reg[REG_DST_GREEN] = MASK_GREEN_RST;
      mask_reg[REG_DST_BLUE]  = MASK_BLUE_RST;
      mask_reg[REG_DST_ALPHA] = MASK_ALPHA_RST;
      errors = 0;
    endfunction

    // Per channel: gather source-mask bits low-first, spread them low-first
    // into the destination mask, OR all channels together.
    function out_req_t repack(in_req_t req);
      out_req_t res;
      pixel_t   compact;
      pixel_t   src;
      pixel_t   dst;
      int       k;
      res.pixel_out = '0;
      res.last_out  = req.last_in;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        src     = mask_reg[int'(REG_SRC_RED) + c];
        dst     = mask_reg[int'(REG_DST_RED) + c];
        compact = '0;
        k = 0;
        for (int i = 0; i < PIXEL_BITS; i++) begin
          if (src[i]) begin
            compact[k] = req.pixel_in[i];
            k++;
          end
        end
        k = 0;
        for (int i = 0; i < PIXEL_BITS; i++) begin
          if (dst[i]) begin
            res.pixel_out[i] = res.pixel_out[i] | compact[k];
            k++;
          end
        end
      end
      return res;
    endfunction

    function void note_request(in_req_t req);
      pending.push_back(repack(req));
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(out_req_t got);
      out_req_t exp;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result pixel_out=%h last_out=%b",
                                  got.pixel_out, got.last_out));
      end else begin
        exp = pending.pop_front();
        if (got.pixel_out !== exp.pixel_out)
          report_mismatch($sformatf("pixel_out %h, expected %h", got.pixel_out, exp.pixel_out));
        if (got.last_out !== exp.last_out)
          report_mismatch($sformatf("last_out %b, expected %b", got.last_out, exp.last_out));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_req_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_req_t              out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  repack_scoreboard sb = new();

  bit quiet;         // end of run: no idling on either side
  bit hold_off_req;  // main asks the receiver for one long hold-off
  int send_gap_pct;  // sender idle chance per request, set per phase

  mask_channel_pixel_repack uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Result monitor: a pixel is taken at a rising edge with valid high and
  // stall low. Values read here are the pre-edge ones.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_data);
  end

  // Receiver: random stall bursts mixed with free-running stretches; on
  // request one long hold-off so the block backs up into in_stall. All
  // changes land on falling edges.
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  // Sender idle: in_valid drops and the payload is scrambled since valid is low.
  task automatic sender_idle(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_data  = in_req_t'({$urandom, 1'($urandom)});
    end
  endtask

  // Offer one request and hold it until the block takes it.
  task automatic send_pixel(pixel_t pix, logic last);
    in_req_t req;
    req.pixel_in = pix;
    req.last_in  = last;
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = req;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
  endtask

  // Drop valid and let every expected pixel come back (bounded).
  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the data
  // at the access-phase rising edge (pready is tied high).
  task automatic write_mask(reg_idx_t idx, pixel_t val);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    sb.mask_reg[idx] = val;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // APB read, compared against our copy of the register.
  task automatic read_mask(reg_idx_t idx);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = CFG_ADDR_W'({idx, 2'b00});
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    if (cfg_prdata !== sb.mask_reg[idx])
      sb.report_mismatch($sformatf("%s reads %h, expected %h",
                                   idx.name(), cfg_prdata, sb.mask_reg[idx]));
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // Load a full layout, then read every register back.
  task automatic load_layout(pixel_t layout[NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++)
      write_mask(reg_idx_t'(i), layout[i]);
    for (int i = 0; i < NUM_REGS; i++)
      read_mask(reg_idx_t'(i));
  endtask

  // Mask shapes: fully random, one contiguous field, empty, full, sparse,
  // a single byte lane.
  function automatic pixel_t random_mask();
    logic [63:0] field;
    int lo;
    int w;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: begin
        lo    = $urandom_range(0, PIXEL_BITS - 1);
        w     = $urandom_range(1, PIXEL_BITS - lo);
        field = ((64'd1 << w) - 64'd1) << lo;
        return pixel_t'(field);
      end
      2: return '0;
      3: return '1;
      4: return $urandom & $urandom;
      default: return pixel_t'(32'h0000_00ff) << (8 * $urandom_range(0, 3));
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // A burst of random pixels with sender gaps at the phase's rate.
  task automatic send_random(int n);
    for (int j = 0; j < n; j++) begin
      if (!quiet && $urandom_range(0, 99) < send_gap_pct)
        sender_idle($urandom_range(1, 16));
      send_pixel(random_pixel(), $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    pixel_t layout[NUM_REGS];
    pixel_t corner_pix[6];

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    quiet        = 1'b0;
    hold_off_req = 1'b0;
    send_gap_pct = 25;

    corner_pix = '{32'h0000_0000, 32'hffff_ffff, 32'h1234_5678,
                   32'h8000_0001, 32'ha5a5_a5a5, 32'h5a5a_5a5a};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: a handful of layouts, three corner pixels each.
    for (int d = 0; d < 7; d++) begin
      layout = sb.mask_reg;
      case (d)
        0: ;  // reset layout, just read it back
        1: layout = '{default: '1};  // every channel takes and fills all bits
        2: layout = '{default: '0};  // every mask empty
        3: begin  // short source: 4 bits gathered into 8-bit lanes
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            layout[int'(REG_SRC_RED) + c] = pixel_t'(32'h0000_000f) << (8 * c);
            layout[int'(REG_DST_RED) + c] = pixel_t'(32'h0000_00ff) << (8 * c);
          end
        end
        4: begin  // short destination, lanes reversed
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            layout[int'(REG_SRC_RED) + c] = pixel_t'(32'h0000_00ff) << (8 * c);
            layout[int'(REG_DST_RED) + c] = pixel_t'(32'h0000_0007) << (8 * (3 - c));
          end
        end
        5: begin  // overlapping sources and destinations
          layout[REG_SRC_RED]   = 32'h0000_ffff;
          layout[REG_SRC_GREEN] = 32'h0000_ffff;
          layout[REG_SRC_BLUE]  = 32'h0000_ffff;
          layout[REG_SRC_ALPHA] = 32'h0000_ffff;
          layout[REG_DST_RED]   = 32'h00ff_ff00;
          layout[REG_DST_GREEN] = 32'h0000_ffff;
          layout[REG_DST_BLUE]  = 32'hffff_0000;
          layout[REG_DST_ALPHA] = 32'hf0f0_f0f0;
        end
        default: begin  // empty source on red, empty destination on green
          layout[REG_SRC_RED]   = '0;
          layout[REG_SRC_GREEN] = MASK_GREEN_RST;
          layout[REG_DST_RED]   = MASK_RED_RST;
          layout[REG_DST_GREEN] = '0;
        end
      endcase
      load_layout(layout);
      for (int j = 0; j < 3; j++)
        send_pixel(corner_pix[(d * 3 + j) % 6], j[0]);
      drain();
    end

    // Random layouts and pixels. One phase runs with the long hold-off, the
    // last one with no idling at all.
    for (int p = 0; p < RAND_PHASES; p++) begin
      for (int i = 0; i < NUM_REGS; i++)
        layout[i] = random_mask();
      load_layout(layout);
      send_gap_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 40);
      if (p == RAND_PHASES - 1)
        quiet = 1'b1;
      if (p == 2) begin
        hold_off_req = 1'b1;
        send_random(40);  // keeps offering while the result side is held
      end
      send_random(PHASE_ITEMS);
      drain();
    end

    // drain() already waited for stray results
    repeat (8) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report_mismatch($sformatf("%0d expected pixels never arrived", sb.pending.size()));
    if (sb.errors == 0) begin
      $display("tb_mask_channel_pixel_repack OK");
    end else begin
      $display("tb_mask_channel_pixel_repack NOT OK");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_mask_channel_pixel_repack NOT OK");
    $finish;
  end

endmodule
